// ===== src/led_sse_pkg.sv =====
// Shared types, opcodes and symbol encoding for the LED strip SPI symbol encoder.
`default_nettype none
package led_sse_pkg;

	localparam int CNT_W       = 5;   // effective LED count, 0..16
	localparam int MAX_RESULTS = 16;
	localparam int CMD_DEPTH   = 2;
	localparam int OUT_DEPTH   = 4;
	localparam int OCW         = $clog2(OUT_DEPTH + 1);

	localparam logic [1:0] OP_SET_ONE = 2'd0;
	localparam logic [1:0] OP_SET_ALL = 2'd1;
	localparam logic [1:0] OP_CLEAR   = 2'd2;
	localparam logic [1:0] OP_FLUSH   = 2'd3;

	localparam logic [1:0] REG_ACTIVE_LEDS  = 2'd0;
	localparam logic [1:0] REG_ONE_PATTERN  = 2'd1;
	localparam logic [1:0] REG_ZERO_PATTERN = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [3:0]  idx;
		logic [23:0] color;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  led;
		logic [23:0] color;
		logic        last;
	} out_t;

	// Eight symbol bytes, color bit 7 of the slice in the top byte.
	function automatic logic [63:0] encode8(input logic [7:0] bits,
			input logic [7:0] one_pat, input logic [7:0] zero_pat);
		logic [63:0] w;
		w = '0;
		for (int k = 0; k < 8; k++) begin
			w[8*k +: 8] = bits[k] ? one_pat : zero_pat;
		end
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== src/led_sse_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module led_sse_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== src/led_sse_fifo.sv =====
// Small register FIFO used for the command queue and the result queue.
`default_nettype none
module led_sse_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rd_data,
	output logic                  full,
	output logic                  empty,
	output logic      [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/led_sse_front.sv =====
// Front end: accepts input items, drops no-op commands, queues the rest.
`default_nettype none
module led_sse_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          push,
	output logic                               full,
	input  wire logic [1:0]                    opcode,
	input  wire logic [3:0]                    led_sel,
	input  wire logic [23:0]                   color,
	input  wire logic [led_sse_pkg::CNT_W-1:0] eff_count,
	output logic                               cmd_valid,
	output led_sse_pkg::cmd_t                  cmd,
	input  wire logic                          cmd_pop
);
	import led_sse_pkg::*;

	cmd_t            in_cmd;
	logic            keep;
	logic            cmd_empty;
	logic [$clog2(CMD_DEPTH + 1)-1:0] cmd_count;
	logic [$bits(cmd_t)-1:0] rd_bits;

	// set-one beyond the count, and set-all/flush with no LEDs, change nothing
	always_comb begin
		case (opcode)
			OP_SET_ONE: keep = ({1'b0, led_sel} < eff_count);
			OP_SET_ALL: keep = (eff_count != '0);
			OP_FLUSH:   keep = (eff_count != '0);
			default:    keep = 1'b1;
		endcase
	end

	assign in_cmd = '{op: opcode, idx: led_sel, color: color};

	led_sse_fifo #(
		.WIDTH($bits(cmd_t)),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push && keep),
		.wr_data(in_cmd),
		.pop    (cmd_pop),
		.rd_data(rd_bits),
		.full   (full),
		.empty  (cmd_empty),
		.count  (cmd_count)
	);

	assign cmd       = cmd_t'(rd_bits);
	assign cmd_valid = !cmd_empty;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_count <= ($clog2(CMD_DEPTH + 1))'(CMD_DEPTH))
		else $error("command queue count out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && keep |=> !cmd_empty)
		else $error("kept command not queued");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd.op == OP_SET_ONE |-> {1'b0, cmd.idx} < eff_count)
		else $error("out-of-range set-one reached the queue head");

endmodule
`default_nettype wire

// ===== src/led_sse_back.sv =====
// Back end: color store, set-all walk and flush read-out into the result queue.
`default_nettype none
module led_sse_back #(
	parameter int STRIP_LEN  = 16,
	parameter int COLOR_BITS = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [led_sse_pkg::CNT_W-1:0] eff_count,
	input  wire logic                          cmd_valid,
	input  wire led_sse_pkg::cmd_t             cmd,
	output logic                               cmd_pop,
	input  wire logic [led_sse_pkg::OCW-1:0]   out_count,
	output logic                               out_push,
	output led_sse_pkg::out_t                  out_data
);
	import led_sse_pkg::*;

	localparam int AW = (STRIP_LEN > 1) ? $clog2(STRIP_LEN) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [23:0]           walk_color_q;
	logic [STRIP_LEN-1:0]  valid_q;
	logic                  rd_pend_s1;
	logic                  rd_vld_s1;
	logic [3:0]            rd_num_s1;
	logic                  rd_last_s1;

	logic                  cnt_last;
	logic                  issue;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [COLOR_BITS-1:0] wdata;
	logic [AW-1:0]         raddr;
	logic [COLOR_BITS-1:0] rdata;

	function automatic logic [AW-1:0] to_addr(input logic [3:0] v);
		logic [AW+3:0] w;
		w = (AW + 4)'(v);
		return w[AW-1:0];
	endfunction

	assign cnt_last = (cnt_q + 1'b1 == eff_count);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;
	// one read in flight at most; it always finds room in the result queue
	assign issue    = (state_q == ST_FLUSH) &&
		((OCW + 1)'(out_count) + (OCW + 1)'(rd_pend_s1) < (OCW + 1)'(OUT_DEPTH));

	assign we    = (cmd_pop && cmd.op == OP_SET_ONE) || (state_q == ST_WALK);
	assign waddr = (state_q == ST_WALK) ? to_addr(cnt_q[3:0]) : to_addr(cmd.idx);
	assign wdata = (state_q == ST_WALK) ? COLOR_BITS'(walk_color_q)
	                                    : COLOR_BITS'(cmd.color);
	assign raddr = to_addr(cnt_q[3:0]);

	led_sse_ram #(
		.WIDTH(COLOR_BITS),
		.DEPTH(STRIP_LEN)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			valid_q    <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			rd_pend_s1 <= issue;
			case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						case (cmd.op)
							OP_SET_ONE: valid_q[to_addr(cmd.idx)] <= 1'b1;
							OP_SET_ALL: begin
								cnt_q   <= '0;
								state_q <= ST_WALK;
							end
							OP_CLEAR:   valid_q <= '0;
							OP_FLUSH: begin
								cnt_q   <= '0;
								state_q <= ST_FLUSH;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					valid_q[to_addr(cnt_q[3:0])] <= 1'b1;
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (issue) begin
						if (cnt_last) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.op == OP_SET_ALL) begin
			walk_color_q <= cmd.color;
		end
		rd_vld_s1  <= valid_q[raddr];
		rd_num_s1  <= cnt_q[3:0];
		rd_last_s1 <= cnt_last;
	end

	// never-written entries read as zero
	assign out_push = rd_pend_s1;
	assign out_data = '{led: rd_num_s1,
	                    color: rd_vld_s1 ? rdata[23:0] : 24'd0,
	                    last: rd_last_s1};

	assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_count < OCW'(OUT_DEPTH))
		else $error("result pushed into a full queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q) == ST_FLUSH)
		else $error("store read outside a flush");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK || state_q == ST_FLUSH) |-> cnt_q < eff_count)
		else $error("walk counter beyond the LED count");

endmodule
`default_nettype wire

// ===== src/led_strip_spi_symbol_encoder.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+-------------------------------------------------
// input     | push / full            | opcode, led_sel, color
// result    | empty / pop            | led_number, symbols_first/middle/final, last
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Set-one and clear are done in the back end from idle; set-all walks the store, and
// flush reads one LED per cycle through the store's single read port while the result
// queue has room.
// Reset clears the per-LED valid bits at once: no clearing pass, ready right after reset.
// A 2-entry command queue and a 4-entry result queue let input and output stall apart.
`default_nettype none
module led_strip_spi_symbol_encoder #(
	parameter int STRIP_LEN  = 16,
	parameter int COLOR_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  opcode,
	input  wire logic [3:0]  led_sel,
	input  wire logic [23:0] color,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       led_number,
	output logic [63:0]      symbols_first,
	output logic [63:0]      symbols_middle,
	output logic [63:0]      symbols_final,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import led_sse_pkg::*;

	localparam int LIMIT = (STRIP_LEN < MAX_RESULTS) ? STRIP_LEN : MAX_RESULTS;

	logic [4:0]       active_leds_q;
	logic [7:0]       one_pattern_q;
	logic [7:0]       zero_pattern_q;
	logic [CNT_W-1:0] eff_count;
	logic             cmd_valid;
	cmd_t             cmd;
	logic             cmd_pop;
	logic [OCW-1:0]   out_count;
	logic             out_push;
	out_t             out_data;
	logic [$bits(out_t)-1:0] head_bits;
	out_t             head;
	logic             out_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_leds_q  <= 5'd16;
			one_pattern_q  <= 8'd248;
			zero_pattern_q <= 8'd192;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_LEDS:  active_leds_q  <= cfg_data[4:0];
				REG_ONE_PATTERN:  one_pattern_q  <= cfg_data;
				REG_ZERO_PATTERN: zero_pattern_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_count = (active_leds_q > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : active_leds_q;

	led_sse_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.led_sel  (led_sel),
		.color    (color),
		.eff_count(eff_count),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	led_sse_back #(
		.STRIP_LEN (STRIP_LEN),
		.COLOR_BITS(COLOR_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.eff_count(eff_count),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.out_count(out_count),
		.out_push (out_push),
		.out_data (out_data)
	);

	led_sse_fifo #(
		.WIDTH($bits(out_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wr_data(out_data),
		.pop    (pop),
		.rd_data(head_bits),
		.full   (out_full),
		.empty  (empty),
		.count  (out_count)
	);

	// user keeps patterns stable while results pend (unenforced); encode at head
	assign head           = out_t'(head_bits);
	assign led_number     = head.led;
	assign last           = head.last;
	assign symbols_first  = encode8(head.color[23:16], one_pattern_q, zero_pattern_q);
	assign symbols_middle = encode8(head.color[15:8], one_pattern_q, zero_pattern_q);
	assign symbols_final  = encode8(head.color[7:0], one_pattern_q, zero_pattern_q);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_full |-> !out_push || (pop && !empty))
		else $error("result queue overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		eff_count <= CNT_W'(LIMIT))
		else $error("effective LED count above limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && last |-> led_number == 4'(eff_count - 1'b1))
		else $error("last flag on the wrong LED");

endmodule
`default_nettype wire
